FILE: rtl/core/wfd_pkg.sv
// shared types and constants for the websocket frame deframer
package wfd_pkg;

  localparam int LenW  = 63;
  localparam int KeyW  = 32;
  localparam int ByteW = 8;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_RSV      = 3'd1;
  localparam logic [2:0] ST_OPCODE   = 3'd2;
  localparam logic [2:0] ST_NO_MASK  = 3'd3;
  localparam logic [2:0] ST_LEN_MSB  = 3'd4;
  localparam logic [2:0] ST_CLOSE    = 3'd5;
  localparam logic [2:0] ST_HALTED   = 3'd6;

  localparam logic [3:0] OP_MAX_DATA = 4'd2;
  localparam logic [3:0] OP_CLOSE    = 4'd8;

  localparam logic [6:0] LEN7_16     = 7'd126;

  typedef enum logic [6:0] {
    PH_HDR0  = 7'b0000001,
    PH_HDR1  = 7'b0000010,
    PH_LEN16 = 7'b0000100,
    PH_LEN64 = 7'b0001000,
    PH_KEY   = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_HALT  = 7'b1000000
  } wfd_phase_t;

  typedef struct packed {
    wfd_phase_t       phase;
    logic [2:0]       byte_cursor;
    logic [LenW-1:0]  payload_len;
    logic [LenW-1:0]  bytes_left;
    logic [KeyW-1:0]  mask_word;
    logic             fin_flag;
    logic [3:0]       opcode_reg;
  } wfd_state_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             is_payload;
    logic             last_of_frame;
    logic             frame_fin;
    logic [3:0]       frame_opcode;
    logic [LenW-1:0]  frame_length;
    logic [2:0]       status;
  } wfd_result_t;

endpackage

FILE: rtl/core/websocket_frame_deframer_unit.sv
// top level of the websocket frame deframer: parse state and result register
//
//  channel   valid          stall          payload
//  input     byte_valid     byte_stall     data_byte
//  result    result_valid   result_stall   out_byte is_payload last_of_frame frame_fin
//                                          frame_opcode frame_length status
//
// one byte per cycle unless the input stalls: each accepted byte yields its result in the next cycle
// from the result register; the parser state updates in the same edge.
// the input stalls only while a held result is itself stalled.
// synchronous reset returns to the first header byte with all state cleared.
// a protocol error halts the parser until reset; later bytes report halted.
module websocket_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  out_byte,
  output logic        is_payload,
  output logic        last_of_frame,
  output logic        frame_fin,
  output logic [3:0]  frame_opcode,
  output logic [62:0] frame_length,
  output logic [2:0]  status
);
  import wfd_pkg::*;

  wfd_state_t  state;
  wfd_state_t  state_next;
  wfd_result_t res_next;
  wfd_result_t res;
  logic        take;

  assign byte_stall = result_valid && result_stall;
  assign take       = byte_valid && !byte_stall;

  wfd_step u_step (
    .state      (state),
    .data_byte  (data_byte),
    .state_next (state_next),
    .result     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_HDR0;
      state.byte_cursor <= '0;
      state.payload_len <= '0;
      state.bytes_left  <= '0;
      state.mask_word   <= '0;
      state.fin_flag    <= 1'b0;
      state.opcode_reg  <= '0;
      result_valid      <= 1'b0;
    end else begin
      if (take) begin
        state <= state_next;
      end
      if (take) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign out_byte      = res.out_byte;
  assign is_payload    = res.is_payload;
  assign last_of_frame = res.last_of_frame;
  assign frame_fin     = res.frame_fin;
  assign frame_opcode  = res.frame_opcode;
  assign frame_length  = res.frame_length;
  assign status        = res.status;

endmodule

FILE: rtl/core/wfd_step.sv
// per-byte header parse, unmask and next-state logic
module wfd_step (
  input  wfd_pkg::wfd_state_t  state,
  input  logic [7:0]           data_byte,
  output wfd_pkg::wfd_state_t  state_next,
  output wfd_pkg::wfd_result_t result
);
  import wfd_pkg::*;

  logic [LenW-1:0] len_shift;
  logic [LenW-1:0] left_dec;
  logic [1:0]      offs;
  logic [7:0]      key_byte;
  logic [2:0]      cursor_inc;
  logic [2:0]      st;
  logic            pay;
  logic            last;
  logic [7:0]      ob;

  assign len_shift  = {state.payload_len[LenW-9:0], data_byte};
  assign left_dec   = state.bytes_left - {{(LenW-1){1'b0}}, 1'b1};
  assign cursor_inc = state.byte_cursor + 3'd1;
  // offset within the payload only matters mod 4
  assign offs       = state.payload_len[1:0] - state.bytes_left[1:0];

  always_comb begin
    unique case (offs)
      2'd0: key_byte = state.mask_word[31:24];
      2'd1: key_byte = state.mask_word[23:16];
      2'd2: key_byte = state.mask_word[15:8];
      2'd3: key_byte = state.mask_word[7:0];
      default: key_byte = state.mask_word[7:0];
    endcase
  end

  always_comb begin
    state_next = state;
    st   = ST_OK;
    pay  = 1'b0;
    last = 1'b0;
    ob   = data_byte;
    unique case (state.phase)
      PH_HDR0: begin
        state_next.byte_cursor = 3'd0;
        state_next.fin_flag    = data_byte[7];
        if (data_byte[6:4] != 3'd0) begin
          st = ST_RSV;
          state_next.phase = PH_HALT;
        end else begin
          state_next.opcode_reg = data_byte[3:0];
          if (data_byte[3:0] <= OP_MAX_DATA) begin
            state_next.phase = PH_HDR1;
          end else begin
            st = (data_byte[3:0] == OP_CLOSE) ? ST_CLOSE : ST_OPCODE;
            state_next.phase = PH_HALT;
          end
        end
      end
      PH_HDR1: begin
        state_next.payload_len = '0;
        if (!data_byte[7]) begin
          st = ST_NO_MASK;
          state_next.phase = PH_HALT;
        end else begin
          state_next.byte_cursor = 3'd0;
          if (data_byte[6:0] < LEN7_16) begin
            state_next.payload_len = {{(LenW-7){1'b0}}, data_byte[6:0]};
            state_next.phase = PH_KEY;
          end else if (data_byte[6:0] == LEN7_16) begin
            state_next.phase = PH_LEN16;
          end else begin
            state_next.phase = PH_LEN64;
          end
        end
      end
      PH_LEN16: begin
        state_next.payload_len = len_shift;
        state_next.byte_cursor = cursor_inc;
        if (cursor_inc >= 3'd2) begin
          state_next.byte_cursor = 3'd0;
          state_next.phase = PH_KEY;
        end
      end
      PH_LEN64: begin
        if (state.byte_cursor == 3'd0 && data_byte[7]) begin
          st = ST_LEN_MSB;
          state_next.phase = PH_HALT;
        end else begin
          state_next.payload_len = len_shift;
          state_next.byte_cursor = cursor_inc;
          if (cursor_inc == 3'd0) begin
            state_next.phase = PH_KEY;
          end
        end
      end
      PH_KEY: begin
        state_next.mask_word   = {state.mask_word[KeyW-9:0], data_byte};
        state_next.byte_cursor = cursor_inc;
        if (cursor_inc >= 3'd4) begin
          state_next.byte_cursor = 3'd0;
          state_next.bytes_left  = state.payload_len;
          if (state.payload_len == '0) begin
            last = 1'b1;
            state_next.phase = PH_HDR0;
          end else begin
            state_next.phase = PH_DATA;
          end
        end
      end
      PH_DATA: begin
        ob  = data_byte ^ key_byte;
        pay = 1'b1;
        state_next.bytes_left = left_dec;
        if (left_dec == '0) begin
          last = 1'b1;
          state_next.phase = PH_HDR0;
        end
      end
      default: begin
        // halted, or a phase code that means nothing
        st = ST_HALTED;
        state_next.phase = PH_HALT;
      end
    endcase
  end

  always_comb begin
    result.out_byte      = ob;
    result.is_payload    = pay;
    result.last_of_frame = last;
    result.frame_fin     = state_next.fin_flag;
    result.frame_opcode  = state_next.opcode_reg;
    result.frame_length  = state_next.payload_len;
    result.status        = st;
  end

endmodule

FILE: rtl/core/wfd_checker.sv
// port-level checks for the websocket frame deframer
module wfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_stall,
  input logic        result_valid,
  input logic        result_stall,
  input logic [7:0]  out_byte,
  input logic        is_payload,
  input logic        last_of_frame,
  input logic [3:0]  frame_opcode,
  input logic [62:0] frame_length,
  input logic [2:0]  status
);
  import wfd_pkg::*;

  // a payload byte belongs to a healthy data frame with nonzero length
  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && is_payload |->
      status == ST_OK && frame_opcode <= OP_MAX_DATA && frame_length != '0)
    else $error("payload byte outside a valid data frame");

  // frame end is never reported together with an error
  a_last_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && last_of_frame |-> status == ST_OK)
    else $error("frame end flagged with error status");

  // every accepted request yields a result on the next cycle
  a_one_per_request: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !byte_stall |=> result_valid)
    else $error("accepted request gave no result");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(out_byte) && $stable(status))
    else $error("stalled result changed");

endmodule

bind websocket_frame_deframer_unit wfd_checker u_wfd_checker (.*);

FILE: bench/websocket_frame_deframer_unit_tb.sv
// self-checking testbench for the websocket frame deframer unit
`timescale 1ns / 1ps

module websocket_frame_deframer_unit_tb;
  import wfd_pkg::*;

  localparam int CYCLE_LIMIT = 400_000;
  localparam int RANDOM_BYTES = 1480;

  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [6:0] LEN7_64   = 7'd127;

  typedef enum int {FORM7, FORM16, FORM64} len_form_t;
  typedef enum int {
    BREAK_RSV, BREAK_OPCODE, BREAK_CLOSE, BREAK_NO_MASK, BREAK_LEN_MSB, HUGE_FRAME
  } tail_kind_t;

  class deframe_scoreboard;
    wfd_phase_t   phase;
    logic [2:0]   cursor;
    logic [62:0]  frame_len;
    logic [62:0]  remaining;
    logic [31:0]  key;
    logic         fin;
    logic [3:0]   opcode;
    wfd_result_t  deframed_q[$];
    int           errors;

    function new();
      phase = PH_HDR0;
      cursor = '0;
      frame_len = '0;
      remaining = '0;
      key = '0;
      fin = 1'b0;
      opcode = '0;
      errors = 0;
    endfunction

    function int pending();
      return deframed_q.size();
    endfunction

    // advance the parser by one request and queue the result it gives
    function void take_request(logic [7:0] b);
      wfd_result_t r;
      logic [1:0] offs;
      r = '0;
      r.out_byte = b;
      r.status = ST_OK;
      case (phase)
        PH_HDR0: begin
          cursor = '0;
          fin = b[7];
          if (b[6:4] != 3'b000) begin
            r.status = ST_RSV;
            phase = PH_HALT;
          end else begin
            opcode = b[3:0];
            if (opcode <= OP_MAX_DATA) begin
              phase = PH_HDR1;
            end else begin
              r.status = (opcode == OP_CLOSE) ? ST_CLOSE : ST_OPCODE;
              phase = PH_HALT;
            end
          end
        end
        PH_HDR1: begin
          frame_len = '0;
          if (!b[7]) begin
            r.status = ST_NO_MASK;
            phase = PH_HALT;
          end else begin
            if (b[6:0] < LEN7_16) begin
              frame_len = 63'(b[6:0]);
              phase = PH_KEY;
            end else if (b[6:0] == LEN7_16) begin
              phase = PH_LEN16;
            end else begin
              phase = PH_LEN64;
            end
            cursor = '0;
          end
        end
        PH_LEN16: begin
          frame_len = {frame_len[54:0], b};
          cursor = cursor + 3'd1;
          if (cursor >= 3'd2) begin
            cursor = '0;
            phase = PH_KEY;
          end
        end
        PH_LEN64: begin
          if (cursor == 3'd0 && b[7]) begin
            r.status = ST_LEN_MSB;
            phase = PH_HALT;
          end else begin
            frame_len = {frame_len[54:0], b};
            cursor = cursor + 3'd1;
            if (cursor == 3'd0) phase = PH_KEY;
          end
        end
        PH_KEY: begin
          key = {key[23:0], b};
          cursor = cursor + 3'd1;
          if (cursor >= 3'd4) begin
            cursor = '0;
            remaining = frame_len;
            // empty frame closes on its last key byte
            if (remaining == '0) begin
              r.last_of_frame = 1'b1;
              phase = PH_HDR0;
            end else begin
              phase = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          offs = frame_len[1:0] - remaining[1:0];
          r.out_byte = b ^ 8'(key >> (24 - 8 * offs));
          r.is_payload = 1'b1;
          remaining = remaining - 63'd1;
          if (remaining == '0) begin
            r.last_of_frame = 1'b1;
            phase = PH_HDR0;
          end
        end
        default: begin
          r.status = ST_HALTED;
          phase = PH_HALT;
        end
      endcase
      r.frame_fin = fin;
      r.frame_opcode = opcode;
      r.frame_length = frame_len;
      deframed_q.push_back(r);
    endfunction

    function void compare(string field, logic [62:0] exp_val, logic [62:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s: expected %0h, got %0h", field, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_result(wfd_result_t got);
      wfd_result_t exp_r;
      if (deframed_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      exp_r = deframed_q.pop_front();
      compare("out_byte", 63'(exp_r.out_byte), 63'(got.out_byte));
      compare("is_payload", 63'(exp_r.is_payload), 63'(got.is_payload));
      compare("last_of_frame", 63'(exp_r.last_of_frame), 63'(got.last_of_frame));
      compare("frame_fin", 63'(exp_r.frame_fin), 63'(got.frame_fin));
      compare("frame_opcode", 63'(exp_r.frame_opcode), 63'(got.frame_opcode));
      compare("frame_length", exp_r.frame_length, got.frame_length);
      compare("status", 63'(exp_r.status), 63'(got.status));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  out_byte;
  logic        is_payload;
  logic        last_of_frame;
  logic        frame_fin;
  logic [3:0]  frame_opcode;
  logic [62:0] frame_length;
  logic [2:0]  status;

  deframe_scoreboard deframer_sb;
  bit calm = 1'b0;
  int sent_count = 0;
  int cycle_count = 0;

  websocket_frame_deframer_unit DUT (
    .clk(clk),
    .rst(rst),
    .byte_valid(byte_valid),
    .byte_stall(byte_stall),
    .data_byte(data_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_byte(out_byte),
    .is_payload(is_payload),
    .last_of_frame(last_of_frame),
    .frame_fin(frame_fin),
    .frame_opcode(frame_opcode),
    .frame_length(frame_length),
    .status(status)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("websocket_frame_deframer_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (byte_valid && !byte_stall) deframer_sb.take_request(data_byte);
      if (result_valid && !result_stall) begin
        deframer_sb.check_result({out_byte, is_payload, last_of_frame, frame_fin,
                                  frame_opcode, frame_length, status});
      end
    end
  end

  function automatic int draw_wait();
    if (calm) return 0;
    return $urandom_range(0, 17);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_header(input logic [7:0] b0, input logic mask_bit,
                             input len_form_t form, input logic [63:0] len,
                             input logic [31:0] key);
    logic [6:0] code;
    case (form)
      FORM7:   code = len[6:0];
      FORM16:  code = LEN7_16;
      default: code = LEN7_64;
    endcase
    send_byte(b0);
    send_byte({mask_bit, code});
    if (form == FORM16) begin
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else if (form == FORM64) begin
      for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
    end
    for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
  endtask

  // pattern below zero means random bytes
  task automatic send_payload(input logic [62:0] n, input int pattern);
    for (longint i = 0; i < n; i++) send_byte(pattern < 0 ? 8'($urandom) : 8'(pattern));
  endtask

  task automatic send_frame(input logic fin, input logic [3:0] op, input len_form_t form,
                            input logic [62:0] len, input logic [31:0] key,
                            input int pattern);
    send_header({fin, 3'b000, op}, 1'b1, form, {1'b0, len}, key);
    send_payload(len, pattern);
  endtask

  task automatic wait_for_results();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (deframer_sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : receiver
    int hold;
    while (rst) @(posedge clk);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      result_stall <= 1'b0;
      @(posedge clk);
      while (!result_valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    len_form_t   form;
    tail_kind_t  tail_kind;
    logic [62:0] len;
    logic [31:0] key;
    logic [3:0]  op;
    int          sel;
    bit          drained_mid;
    deframer_sb = new();
    drained_mid = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // short directed frames: empty frame, 16-bit and 64-bit length forms, key extremes
    send_frame(1'b1, OP_TEXT, FORM7, 63'd0, 32'hFFFF_FFFF, -1);
    send_frame(1'b0, OP_CONT, FORM16, 63'd1, 32'hFFFF_FFFF, 8'h00);
    send_frame(1'b1, OP_BINARY, FORM64, 63'd2, 32'h0000_0000, 8'hFF);
    wait_for_results();

    while (sent_count < RANDOM_BYTES) begin
      calm = ($urandom_range(0, 7) == 0);
      sel = $urandom_range(0, 99);
      form = (sel < 70) ? FORM7 : (sel < 85) ? FORM16 : FORM64;
      sel = $urandom_range(0, 19);
      if (sel == 0) len = (form == FORM7) ? 63'd125 : 63'($urandom_range(126, 300));
      else if (sel < 3) len = 63'($urandom_range(0, 125));
      else len = 63'($urandom_range(0, 12));
      sel = $urandom_range(0, 9);
      key = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : $urandom;
      send_frame(1'($urandom), 4'($urandom_range(OP_CONT, OP_BINARY)), form, len, key, -1);
      if (!drained_mid && sent_count > RANDOM_BYTES / 2) begin
        wait_for_results();
        drained_mid = 1'b1;
      end
    end
    calm = 1'b0;
    wait_for_results();

    // only one halt per run, so the ending is picked at random
    tail_kind = tail_kind_t'($urandom_range(BREAK_RSV, HUGE_FRAME));
    key = $urandom;
    case (tail_kind)
      BREAK_RSV: begin
        send_header({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)}, 1'b1, FORM7,
                    64'd5, key);
      end
      BREAK_OPCODE: begin
        op = 4'($urandom_range(3, 14));
        if (op >= OP_CLOSE) op = op + 4'd1;
        send_header({1'($urandom), 3'b000, op}, 1'b1, FORM7, 64'd5, key);
      end
      BREAK_CLOSE: begin
        send_header({1'($urandom), 3'b000, OP_CLOSE}, 1'b1, FORM7, 64'd5, key);
      end
      BREAK_NO_MASK: begin
        send_header({1'($urandom), 3'b000, OP_TEXT}, 1'b0, FORM7,
                    64'($urandom_range(0, 125)), key);
      end
      BREAK_LEN_MSB: begin
        send_header({1'b1, 3'b000, OP_BINARY}, 1'b1, FORM64,
                    {8'($urandom_range(128, 255)), 56'({$urandom, $urandom})}, key);
      end
      default: begin
        // largest lengths: payload never ends within the run
        send_header({1'b1, 3'b000, OP_BINARY}, 1'b1, FORM64,
                    {8'h7F, ($urandom_range(0, 1) != 0) ? {56{1'b1}}
                                                        : 56'({$urandom, $urandom})},
                    key);
      end
    endcase
    send_payload(63'd24, -1);
    wait_for_results();
    repeat (8) @(posedge clk);

    if (deframer_sb.errors == 0 && deframer_sb.pending() == 0) begin
      $display("websocket_frame_deframer_unit: match");
    end else begin
      $display("websocket_frame_deframer_unit: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/wfd_pkg.sv
rtl/core/wfd_step.sv
rtl/core/websocket_frame_deframer_unit.sv
rtl/core/wfd_checker.sv
bench/websocket_frame_deframer_unit_tb.sv
